@@ rtl/sbx_pkg.sv @@
// sbx_pkg: shared types, operation codes and mask helpers for the sprite xor blitter
// used by every module of the block; depends on nothing
`timescale 1ns / 1ps
`default_nettype none

package sbx_pkg;

    localparam int SCREEN_WIDTH_DEF  = 128;
    localparam int SCREEN_HEIGHT_DEF = 64;

    localparam int PIX_W   = 128;  // widest frame row in pixels
    localparam int WORD_W  = 64;   // one frame store word
    localparam int ADDR_W  = 7;    // word address at the tallest screen
    localparam int STEP_W  = 8;    // sequencer step count
    localparam int TALLY_W = 5;

    localparam logic [TALLY_W-1:0] TALLY_MAX = 5'd31;

    localparam logic [2:0] OP_DRAW      = 3'd0;
    localparam logic [2:0] OP_CLEAR     = 3'd1;
    localparam logic [2:0] OP_SCROLL_DN = 3'd2;
    localparam logic [2:0] OP_SCROLL_RT = 3'd3;
    localparam logic [2:0] OP_SCROLL_LT = 3'd4;
    localparam logic [2:0] OP_READ      = 3'd5;

    typedef struct packed {
        logic [2:0]  op;
        logic [7:0]  x_pos;
        logic [7:0]  y_pos;
        logic [3:0]  row_index;
        logic [15:0] row_bits;
        logic        wide;
        logic        hires;
        logic [3:0]  scroll_rows;
        logic [5:0]  read_row;
        logic        read_half;
        logic        last_row;
    } t_item;

    typedef struct packed {
        logic               row_collided;
        logic [TALLY_W-1:0] flag_value;
        logic               sprite_done;
        logic [WORD_W-1:0]  read_data;
    } t_result;

    typedef struct packed {
        logic              wr_en;
        logic [ADDR_W-1:0] wr_addr;
        logic [ADDR_W-1:0] rd_addr;
        logic              clr_all;
    } t_mem_req;

    typedef struct packed {
        logic idle;
        logic last_phase;
    } t_ctrl_sts;

    // pixels left of the screen width set, leftmost pixel in the top bit
    function automatic logic [PIX_W-1:0] vis_mask(input int width);
        return ~({PIX_W{1'b1}} >> width);
    endfunction

    // every pattern bit becomes two adjacent pixels
    function automatic logic [15:0] dbl_byte(input logic [7:0] b);
        logic [15:0] d;
        for (int k = 0; k < 8; k++) begin
            d[2*k]   = b[k];
            d[2*k+1] = b[k];
        end
        return d;
    endfunction

endpackage

`default_nettype wire

@@ rtl/sbx_frame_mem.sv @@
// sbx_frame_mem: frame store, one write and one registered read port, 64-bit words
// per-word valid bits give the all-zero reset and an instant clear; uses sbx_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbx_frame_mem #(
    parameter int SCREEN_HEIGHT = sbx_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                          i_clk,
    input  wire logic                          i_rst_n,
    input  wire sbx_pkg::t_mem_req             i_req,
    input  wire logic [sbx_pkg::WORD_W-1:0]    i_wr_data,
    output logic      [sbx_pkg::WORD_W-1:0]    o_rd_data
);

    localparam int AW    = $clog2(2 * SCREEN_HEIGHT);
    localparam int DEPTH = 1 << AW;

    logic [sbx_pkg::WORD_W-1:0] r_mem [DEPTH];
    logic [DEPTH-1:0]           r_vld;
    logic [sbx_pkg::WORD_W-1:0] r_rd_data;
    logic                       r_rd_vld;

    always_ff @(posedge i_clk) begin
        if (i_req.wr_en) begin
            r_mem[i_req.wr_addr[AW-1:0]] <= i_wr_data;
        end
        r_rd_data <= r_mem[i_req.rd_addr[AW-1:0]];
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld    <= '0;
            r_rd_vld <= 1'b0;
        end else begin
            if (i_req.clr_all) begin
                r_vld <= '0;
            end else if (i_req.wr_en) begin
                r_vld[i_req.wr_addr[AW-1:0]] <= 1'b1;
            end
            r_rd_vld <= r_vld[i_req.rd_addr[AW-1:0]];
        end
    end

    // a word never written since reset or clear reads as blank
    assign o_rd_data = r_rd_vld ? r_rd_data : '0;

endmodule

`default_nettype wire

@@ rtl/sbx_mask.sv @@
// sbx_mask: places a sprite row on a 128-pixel line, with the lores copy window
// clipped at the right edge; uses sbx_pkg
`timescale 1ns / 1ps
`default_nettype none

module sbx_mask #(
    parameter int SCREEN_WIDTH = sbx_pkg::SCREEN_WIDTH_DEF
) (
    input  wire sbx_pkg::t_item              i_item,
    output logic [sbx_pkg::PIX_W-1:0]        o_pat,
    output logic [sbx_pkg::PIX_W-1:0]        o_win
);

    localparam int PW = sbx_pkg::PIX_W;
    localparam logic [PW-1:0] VIS = sbx_pkg::vis_mask(SCREEN_WIDTH);

    logic [15:0] w_pat16;
    logic [6:0]  w_sh;

    always_comb begin
        if (i_item.hires) begin
            w_pat16 = i_item.wide ? i_item.row_bits : {i_item.row_bits[7:0], 8'h00};
            w_sh    = i_item.x_pos[6:0];
        end else begin
            w_pat16 = sbx_pkg::dbl_byte(i_item.row_bits[7:0]);
            w_sh    = {i_item.x_pos[5:0], 1'b0};
        end
    end

    assign o_pat = ({w_pat16, {(PW-16){1'b0}}} >> w_sh) & VIS;

    // 32-pixel window on a 16-pixel boundary for the lower row copy
    assign o_win = ({{32{1'b1}}, {(PW-32){1'b0}}} >> {i_item.x_pos[5:3], 4'b0000}) & VIS;

endmodule

`default_nettype wire

@@ rtl/sbx_ctrl.sv @@
// sbx_ctrl: sequencer that walks frame store words, one read a cycle, and writes
// each changed word back; uses sbx_pkg and sbx_mask
`timescale 1ns / 1ps
`default_nettype none

module sbx_ctrl #(
    parameter int SCREEN_WIDTH  = sbx_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sbx_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic                        i_clk,
    input  wire logic                        i_rst_n,
    input  wire logic                        i_start,
    input  wire sbx_pkg::t_item              i_item,
    input  wire logic                        i_slot_free,
    output sbx_pkg::t_ctrl_sts               o_sts,
    output logic                             o_fin,
    output sbx_pkg::t_result                 o_res,
    output sbx_pkg::t_mem_req                o_mem_req,
    output logic [sbx_pkg::WORD_W-1:0]       o_wr_data,
    input  wire logic [sbx_pkg::WORD_W-1:0]  i_rd_data
);

    localparam int PW = sbx_pkg::PIX_W;
    localparam int WW = sbx_pkg::WORD_W;
    localparam int SW = sbx_pkg::STEP_W;
    localparam int AW = sbx_pkg::ADDR_W;
    localparam int TW = sbx_pkg::TALLY_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_RUN  = 2'd1;
    localparam logic [1:0] ST_HOLD = 2'd2;

    localparam logic [SW-1:0] WORDS = SW'(2 * SCREEN_HEIGHT);
    localparam logic [6:0]    ROWS  = 7'(SCREEN_HEIGHT);
    localparam logic [PW-1:0] VIS   = sbx_pkg::vis_mask(SCREEN_WIDTH);
    localparam logic [WW-1:0] M0    = VIS[PW-1:WW];
    localparam logic [WW-1:0] M1    = VIS[WW-1:0];

    logic [1:0]             r_state;
    logic [SW-1:0]          r_k;
    sbx_pkg::t_item         r_item;
    logic                   r_coll;
    logic [TW-1:0]          r_tally;
    logic [WW-1:0]          r_newu0;
    logic [WW-1:0]          r_newu1;
    logic [WW-1:0]          r_hi;
    logic [WW-1:0]          r_nl;
    sbx_pkg::t_result       r_res;

    logic [TW-1:0]          n_tally;

    logic [PW-1:0]          w_pat;
    logic [PW-1:0]          w_win;
    logic [6:0]             w_row_u;
    logic [6:0]             w_row_l;
    logic [6:0]             w_rd_row;
    logic [6:0]             w_wr_row;
    logic                   w_pat_nz;
    logic                   w_up_on;
    logic                   w_lo_on;
    logic [SW-1:0]          w_last;
    logic [SW-1:0]          w_j;
    logic [SW-1:0]          w_jm1;
    logic                   w_dv;
    logic                   w_final;
    logic [SW-1:0]          w_rd_dest;
    logic [SW-1:0]          w_rd_src;
    logic [SW-1:0]          w_dn_dest;
    logic                   w_dn_zero;
    logic [WW-1:0]          w_pu;
    logic [WW-1:0]          w_wh;
    logic [WW-1:0]          w_nh;
    logic [WW-1:0]          w_nl;
    logic                   w_hit;
    logic [TW-1:0]          w_tally_inc;
    sbx_pkg::t_mem_req      w_req;
    logic [WW-1:0]          w_wdata;
    sbx_pkg::t_result       w_res;

    sbx_mask #(
        .SCREEN_WIDTH (SCREEN_WIDTH)
    ) u_mask (
        .i_item (r_item),
        .o_pat  (w_pat),
        .o_win  (w_win)
    );

    // sprite row placement
    always_comb begin
        if (r_item.hires) begin
            w_row_u = {1'b0, r_item.y_pos[5:0]} + {3'b000, r_item.row_index};
        end else begin
            w_row_u = {1'b0, r_item.y_pos[4:0], 1'b0} + {2'b00, r_item.row_index, 1'b0};
        end
    end

    assign w_row_l  = w_row_u + 7'd1;
    assign w_pat_nz = (r_item.hires && r_item.wide) ? (|r_item.row_bits)
                                                    : (|r_item.row_bits[7:0]);
    assign w_up_on  = (w_row_u < ROWS) && w_pat_nz;
    assign w_lo_on  = !r_item.hires && w_up_on && (w_row_l < ROWS);

    always_comb begin
        case (r_item.op)
            sbx_pkg::OP_DRAW:      w_last = SW'(3);
            sbx_pkg::OP_SCROLL_DN: w_last = WORDS - 1'b1;
            sbx_pkg::OP_SCROLL_RT,
            sbx_pkg::OP_SCROLL_LT: w_last = WORDS;
            default:               w_last = '0;
        endcase
    end

    // read issue runs one step ahead of the write-back
    assign w_j     = r_k - 1'b1;
    assign w_jm1   = w_j - 1'b1;
    assign w_dv    = (r_state == ST_RUN) && (r_k != '0);
    assign w_final = (r_state == ST_RUN) && (r_k == w_last + 1'b1);

    assign w_rd_row  = r_k[1] ? w_row_l : w_row_u;
    assign w_wr_row  = w_j[1] ? w_row_l : w_row_u;

    // scroll down walks the words from the bottom up
    assign w_rd_dest = WORDS - 1'b1 - r_k;
    assign w_rd_src  = w_rd_dest - {3'b000, r_item.scroll_rows, 1'b0};
    assign w_dn_dest = WORDS - 1'b1 - w_j;
    assign w_dn_zero = w_dn_dest < {3'b000, r_item.scroll_rows, 1'b0};

    assign w_pu = w_j[0] ? w_pat[WW-1:0] : w_pat[PW-1:WW];
    assign w_wh = w_j[0] ? w_win[WW-1:0] : w_win[PW-1:WW];

    assign w_nh = (r_item.op == sbx_pkg::OP_SCROLL_RT) ? {4'h0, r_hi[WW-1:4]}
                                                       : {r_hi[WW-5:0], i_rd_data[WW-1:WW-4]};
    assign w_nl = (r_item.op == sbx_pkg::OP_SCROLL_RT) ? {r_hi[3:0], i_rd_data[WW-1:4]}
                                                       : {i_rd_data[WW-5:0], 4'h0};

    always_comb begin
        w_req   = '0;
        w_wdata = '0;
        w_hit   = 1'b0;
        case (r_item.op)
            sbx_pkg::OP_DRAW: begin
                w_req.rd_addr = {w_rd_row[5:0], r_k[0]};
            end
            sbx_pkg::OP_SCROLL_DN: begin
                w_req.rd_addr = w_rd_src[AW-1:0];
            end
            sbx_pkg::OP_SCROLL_RT, sbx_pkg::OP_SCROLL_LT: begin
                w_req.rd_addr = r_k[AW-1:0];
            end
            sbx_pkg::OP_READ: begin
                w_req.rd_addr = {r_item.read_row, r_item.read_half};
            end
            default: begin
                w_req.rd_addr = '0;
            end
        endcase
        if (w_dv) begin
            case (r_item.op)
                sbx_pkg::OP_DRAW: begin
                    w_req.wr_addr = {w_wr_row[5:0], w_j[0]};
                    if (!w_j[1]) begin
                        w_wdata      = i_rd_data ^ w_pu;
                        w_req.wr_en  = w_up_on;
                        w_hit        = w_up_on && (|(i_rd_data & w_pu));
                    end else begin
                        // lower row copies the new upper row inside the window
                        w_wdata     = ((w_j[0] ? r_newu1 : r_newu0) & w_wh) | (i_rd_data & ~w_wh);
                        w_req.wr_en = w_lo_on;
                    end
                end
                sbx_pkg::OP_SCROLL_DN: begin
                    w_req.wr_addr = w_dn_dest[AW-1:0];
                    w_wdata       = w_dn_zero ? '0 : i_rd_data;
                    w_req.wr_en   = 1'b1;
                end
                sbx_pkg::OP_SCROLL_RT, sbx_pkg::OP_SCROLL_LT: begin
                    // each row half lands while the next row's same half is read
                    w_req.wr_addr = w_jm1[AW-1:0];
                    if (w_j[0]) begin
                        w_wdata     = w_nh & M0;
                        w_req.wr_en = 1'b1;
                    end else begin
                        w_wdata     = r_nl;
                        w_req.wr_en = (w_j != '0);
                    end
                end
                sbx_pkg::OP_CLEAR: begin
                    w_req.clr_all = w_final;
                end
                default: begin
                    w_req.wr_en = 1'b0;
                end
            endcase
        end
    end

    assign w_tally_inc = (r_coll && (r_tally != sbx_pkg::TALLY_MAX)) ? r_tally + 1'b1 : r_tally;
    assign n_tally     = r_item.last_row ? '0 : w_tally_inc;

    always_comb begin
        w_res = '0;
        case (r_item.op)
            sbx_pkg::OP_DRAW: begin
                w_res.row_collided = r_coll;
                w_res.flag_value   = r_item.hires ? w_tally_inc
                                                  : {{(TW-1){1'b0}}, (w_tally_inc != '0)};
                w_res.sprite_done  = r_item.last_row;
            end
            sbx_pkg::OP_READ: begin
                if ({1'b0, r_item.read_row} < ROWS) begin
                    w_res.read_data = i_rd_data & (r_item.read_half ? M1 : M0);
                end
            end
            default: begin
                w_res = '0;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_item <= i_item;
        end
        if (w_dv && (r_item.op == sbx_pkg::OP_DRAW) && (w_j == SW'(0))) begin
            r_newu0 <= w_wdata;
        end
        if (w_dv && (r_item.op == sbx_pkg::OP_DRAW) && (w_j == SW'(1))) begin
            r_newu1 <= w_wdata;
        end
        if (w_dv && ((r_item.op == sbx_pkg::OP_SCROLL_RT) ||
                     (r_item.op == sbx_pkg::OP_SCROLL_LT))) begin
            if (w_j[0]) begin
                r_nl <= w_nl & M1;
            end else begin
                r_hi <= i_rd_data;
            end
        end
        if (w_final && !i_slot_free) begin
            r_res <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
            r_k     <= '0;
            r_coll  <= 1'b0;
            r_tally <= '0;
        end else begin
            if (i_start) begin
                r_state <= ST_RUN;
                r_k     <= '0;
                r_coll  <= 1'b0;
            end else begin
                case (r_state)
                    ST_IDLE: begin
                        r_k <= '0;
                    end
                    ST_RUN: begin
                        if (w_final) begin
                            r_state <= i_slot_free ? ST_IDLE : ST_HOLD;
                        end else begin
                            r_k <= r_k + 1'b1;
                        end
                        if (w_hit) begin
                            r_coll <= 1'b1;
                        end
                    end
                    ST_HOLD: begin
                        if (i_slot_free) begin
                            r_state <= ST_IDLE;
                        end
                    end
                    default: begin
                        r_state <= ST_IDLE;
                    end
                endcase
            end
            if (w_final && (r_item.op == sbx_pkg::OP_DRAW)) begin
                r_tally <= n_tally;
            end
        end
    end

    assign o_sts.idle       = (r_state == ST_IDLE);
    assign o_sts.last_phase = w_final;
    assign o_fin            = (w_final || (r_state == ST_HOLD)) && i_slot_free;
    assign o_res            = (r_state == ST_HOLD) ? r_res : w_res;
    assign o_mem_req        = w_req;
    assign o_wr_data        = w_wdata;

endmodule

`default_nettype wire

@@ rtl/sprite_xor_blitter_with_scroll.sv @@
// sprite_xor_blitter_with_scroll: stream wrapper, output register and frame store
// depends on sbx_pkg, sbx_ctrl, sbx_mask and sbx_frame_mem
//
// one request on the slave stream gives one result on the master stream.
// the operation code comes in tuser; tlast marks the last row of a sprite and
// comes back as tlast on the draw result that closes the sprite.
// the frame lives in a memory of 64-bit words with one read and one write port;
// the sequencer reads one word per cycle and writes each changed word back.
// a draw walks the two halves of its row, and two more words for the lores
// lower row; a read fetches one word; scroll down, left and right walk every
// word of the frame, one read at a time through the single read port.
// the next request is taken on the edge that delivers the previous result if
// the output register is empty then; else it waits until the sequencer is idle.
// reset clears the collision tally and marks every word blank through per-word
// valid bits, so there is no clearing pass; clear works the same way in one go.
// a stalled master side holds its result in the output register while the next
// request is still taken; a second result then waits inside the sequencer and
// no further request is taken until the first one leaves.
`timescale 1ns / 1ps
`default_nettype none

module sprite_xor_blitter_with_scroll #(
    parameter int SCREEN_WIDTH  = sbx_pkg::SCREEN_WIDTH_DEF,
    parameter int SCREEN_HEIGHT = sbx_pkg::SCREEN_HEIGHT_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // x_pos[7:0], y_pos[15:8], row_index[19:16], row_bits[35:20], wide[36],
    // hires[37], scroll_rows[41:38], read_row[47:42], read_half[48], zeros above
    input  wire logic [55:0] s_axis_tdata,
    // operation[2:0]
    input  wire logic [2:0]  s_axis_tuser,
    input  wire logic        s_axis_tlast,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // row_collided[0], flag_value[5:1], read_data[69:6], zeros above
    output logic [71:0]      m_axis_tdata,
    output logic             m_axis_tlast
);

    sbx_pkg::t_item       w_item;
    sbx_pkg::t_ctrl_sts   w_sts;
    sbx_pkg::t_result     w_res;
    sbx_pkg::t_mem_req    w_mem_req;
    logic [sbx_pkg::WORD_W-1:0] w_wr_data;
    logic [sbx_pkg::WORD_W-1:0] w_rd_data;
    logic                 w_fin;
    logic                 w_slot_free;
    logic                 w_start;

    logic                 r_out_valid;
    sbx_pkg::t_result     r_out;

    assign w_item.op          = s_axis_tuser;
    assign w_item.x_pos       = s_axis_tdata[7:0];
    assign w_item.y_pos       = s_axis_tdata[15:8];
    assign w_item.row_index   = s_axis_tdata[19:16];
    assign w_item.row_bits    = s_axis_tdata[35:20];
    assign w_item.wide        = s_axis_tdata[36];
    assign w_item.hires       = s_axis_tdata[37];
    assign w_item.scroll_rows = s_axis_tdata[41:38];
    assign w_item.read_row    = s_axis_tdata[47:42];
    assign w_item.read_half   = s_axis_tdata[48];
    assign w_item.last_row    = s_axis_tlast;

    // a request may enter on the edge the previous result moves out
    assign s_axis_tready = w_sts.idle || (w_sts.last_phase && !r_out_valid);
    assign w_start       = s_axis_tvalid && s_axis_tready;
    assign w_slot_free   = !r_out_valid || m_axis_tready;

    sbx_ctrl #(
        .SCREEN_WIDTH  (SCREEN_WIDTH),
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (w_start),
        .i_item      (w_item),
        .i_slot_free (w_slot_free),
        .o_sts       (w_sts),
        .o_fin       (w_fin),
        .o_res       (w_res),
        .o_mem_req   (w_mem_req),
        .o_wr_data   (w_wr_data),
        .i_rd_data   (w_rd_data)
    );

    sbx_frame_mem #(
        .SCREEN_HEIGHT (SCREEN_HEIGHT)
    ) u_frame_mem (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_req     (w_mem_req),
        .i_wr_data (w_wr_data),
        .o_rd_data (w_rd_data)
    );

    always_ff @(posedge i_clk) begin
        if (w_fin) begin
            r_out <= w_res;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_fin) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {2'b00, r_out.read_data, r_out.flag_value, r_out.row_collided};
    assign m_axis_tlast  = r_out.sprite_done;

endmodule

`default_nettype wire
